// ===== hdl/http_start_line_classifier_unit_defines.svh =====
`ifndef HTTP_START_LINE_CLASSIFIER_UNIT_DEFINES_SVH
`define HTTP_START_LINE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HSLC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hslc: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HSLC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hslc: assertion failed");

`endif

// ===== hdl/hslc_pkg.sv =====
`default_nettype none

package hslc_pkg;

    typedef enum logic [1:0] {
        VERDICT_UNDECIDED = 2'd0,
        VERDICT_REQUEST   = 2'd1,
        VERDICT_RESPONSE  = 2'd2,
        VERDICT_NEITHER   = 2'd3
    } verdict_t;

    localparam logic [4:0] PH_START   = 5'd0;
    localparam logic [4:0] PH_REQ_E   = 5'd1;
    localparam logic [4:0] PH_REQ_T   = 5'd2;
    localparam logic [4:0] PH_REQ_SP  = 5'd3;
    localparam logic [4:0] PH_URI     = 5'd4;
    localparam logic [4:0] PH_RQV_H   = 5'd5;
    localparam logic [4:0] PH_RQV_DIG = 5'd12;
    localparam logic [4:0] PH_RQ_CR   = 5'd13;
    localparam logic [4:0] PH_RQ_LF   = 5'd14;
    localparam logic [4:0] PH_RSV_T   = 5'd15;
    localparam logic [4:0] PH_RSV_DIG = 5'd21;
    localparam logic [4:0] PH_RS_SP1  = 5'd22;
    localparam logic [4:0] PH_CODE0   = 5'd23;
    localparam logic [4:0] PH_RS_SP2  = 5'd26;
    localparam logic [4:0] PH_REASON  = 5'd27;
    localparam logic [4:0] PH_RS_LF   = 5'd28;
    localparam logic [4:0] PH_DONE    = 5'd29;

    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_D0  = 8'h30;
    localparam logic [7:0] CH_D1  = 8'h31;
    localparam logic [7:0] CH_D9  = 8'h39;
    localparam logic [7:0] CH_VIS_LO = 8'h21;
    localparam logic [7:0] CH_VIS_HI = 8'h7E;

    typedef struct packed {
        logic [4:0] phase;
        verdict_t   verdict;
    } hslc_state_t;

    // "HTTP/1." by position
    function automatic logic [7:0] ver_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/http_start_line_classifier_unit.sv =====
// A beat accepted into the input register moves on to the result register, where its verdict shows.
// Throughput: one byte per cycle unless out_stall backs up; the input register and the
// result register form a two-entry pipe, so one more byte is taken while a result waits.
// The grammar state updates as a byte moves from the input register to the result register.
// Reset (rst_n low, asynchronous): both stages empty, phase at line start, verdict undecided.
`default_nettype none

`include "http_start_line_classifier_unit_defines.svh"

module http_start_line_classifier_unit
    import hslc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic        out_valid_reg;
    verdict_t    verdict_reg;
    hslc_state_t state_reg;
    hslc_state_t state_next;
    logic        out_free;
    logic        move;
    logic        in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign move     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    hslc_matcher u_matcher (
        .cur        (state_reg),
        .byte_in    (s1_byte_reg),
        .first_byte (s1_first_reg),
        .last_byte  (s1_last_reg),
        .nxt        (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg.phase   <= PH_START;
            state_reg.verdict <= VERDICT_UNDECIDED;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= byte_in;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end
        if (move)
        begin
            verdict_reg <= state_next.verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // a decided verdict always parks the grammar in the done phase
    `HSLC_ASSERT_IMP(a_done_iff_decided,
        1'b1, ((state_reg.verdict != VERDICT_UNDECIDED) == (state_reg.phase == PH_DONE)))
    // once decided, bytes without a first flag leave the state alone
    `HSLC_ASSERT_NXT(a_verdict_holds,
        move && !s1_first_reg && (state_reg.verdict != VERDICT_UNDECIDED), $stable(state_reg))
    // a last beat always resolves the verdict
    `HSLC_ASSERT_NXT(a_last_decides,
        move && s1_last_reg, out_valid_reg && (verdict_reg != VERDICT_UNDECIDED))
    // result beat shows the state just written
    `HSLC_ASSERT_NXT(a_out_matches_state,
        move, verdict_reg == state_reg.verdict)

endmodule

`default_nettype wire

// ===== hdl/hslc_matcher.sv =====
`default_nettype none

module hslc_matcher
    import hslc_pkg::*;
(
    input  hslc_state_t cur,
    input  logic [7:0]  byte_in,
    input  logic        first_byte,
    input  logic        last_byte,
    output hslc_state_t nxt
);

    logic [4:0] ph;
    verdict_t   v;
    logic [4:0] adv_ph;
    verdict_t   adv_v;
    logic [2:0] ver_idx;
    logic       is_digit;
    logic       is_vis;

    // first byte restarts the grammar before the byte is used
    assign ph = first_byte ? PH_START : cur.phase;
    assign v  = first_byte ? VERDICT_UNDECIDED : cur.verdict;

    assign is_digit = (byte_in >= CH_D0) && (byte_in <= CH_D9);
    assign is_vis   = (byte_in >= CH_VIS_LO) && (byte_in <= CH_VIS_HI);

    always_comb
    begin
        ver_idx = 3'd0;
        if (ph >= PH_RSV_T)
        begin
            ver_idx = 3'(ph - PH_RSV_T + 5'd1);
        end
        else
        begin
            ver_idx = 3'(ph - PH_RQV_H);
        end
    end

    always_comb
    begin
        adv_ph = PH_DONE;
        adv_v  = VERDICT_NEITHER;
        if (ph == PH_START)
        begin
            if (byte_in == 8'h47)
            begin
                adv_ph = PH_REQ_E;
                adv_v  = VERDICT_UNDECIDED;
            end
            else if (byte_in == 8'h48)
            begin
                adv_ph = PH_RSV_T;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_REQ_E)
        begin
            if (byte_in == 8'h45)
            begin
                adv_ph = PH_REQ_T;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_REQ_T)
        begin
            if (byte_in == 8'h54)
            begin
                adv_ph = PH_REQ_SP;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_REQ_SP)
        begin
            if (byte_in == CH_SP)
            begin
                adv_ph = PH_URI;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_URI)
        begin
            if (is_vis)
            begin
                adv_ph = PH_URI;
                adv_v  = VERDICT_UNDECIDED;
            end
            else if (byte_in == CH_SP)
            begin
                adv_ph = PH_RQV_H;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if ((ph >= PH_RQV_H) && (ph < PH_RQV_DIG))
        begin
            if (byte_in == ver_char(ver_idx))
            begin
                adv_ph = ph + 5'd1;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_RQV_DIG)
        begin
            if ((byte_in == CH_D0) || (byte_in == CH_D1))
            begin
                adv_ph = PH_RQ_CR;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_RQ_CR)
        begin
            if (byte_in == CH_CR)
            begin
                adv_ph = PH_RQ_LF;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_RQ_LF)
        begin
            if (byte_in == CH_LF)
            begin
                adv_v = VERDICT_REQUEST;
            end
        end
        else if ((ph >= PH_RSV_T) && (ph < PH_RSV_DIG))
        begin
            // 'H' was taken at line start
            if (byte_in == ver_char(ver_idx))
            begin
                adv_ph = ph + 5'd1;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_RSV_DIG)
        begin
            if ((byte_in == CH_D0) || (byte_in == CH_D1))
            begin
                adv_ph = PH_RS_SP1;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_RS_SP1)
        begin
            if (byte_in == CH_SP)
            begin
                adv_ph = PH_CODE0;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if ((ph >= PH_CODE0) && (ph < PH_RS_SP2))
        begin
            if (is_digit)
            begin
                adv_ph = ph + 5'd1;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_RS_SP2)
        begin
            if (byte_in == CH_SP)
            begin
                adv_ph = PH_REASON;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_REASON)
        begin
            if ((byte_in == CH_TAB) || (byte_in == CH_SP) || is_vis)
            begin
                adv_ph = PH_REASON;
                adv_v  = VERDICT_UNDECIDED;
            end
            else if (byte_in == CH_CR)
            begin
                adv_ph = PH_RS_LF;
                adv_v  = VERDICT_UNDECIDED;
            end
        end
        else if (ph == PH_RS_LF)
        begin
            if (byte_in == CH_LF)
            begin
                adv_v = VERDICT_RESPONSE;
            end
        end
    end

    always_comb
    begin
        nxt.phase   = ph;
        nxt.verdict = v;
        if (v == VERDICT_UNDECIDED)
        begin
            if ((adv_v == VERDICT_UNDECIDED) && last_byte)
            begin
                nxt.phase   = PH_DONE;
                nxt.verdict = VERDICT_NEITHER;
            end
            else
            begin
                nxt.phase   = adv_ph;
                nxt.verdict = adv_v;
            end
        end
    end

endmodule

`default_nettype wire
